// ===== rtl/apifrd_pkg.sv =====
package apifrd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned PosW  = 16;
  localparam int unsigned KindW = 2;
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  // Register indexes on the configuration port (byte address is 4 * index).
  localparam logic [2:0] REG_FRAME_START  = 3'd0;
  localparam logic [2:0] REG_RX_PKT_TYPE  = 3'd1;
  localparam logic [2:0] REG_AT_RESP_TYPE = 3'd2;
  localparam logic [2:0] REG_TX_STAT_TYPE = 3'd3;
  localparam logic [2:0] REG_HDR_SKIP     = 3'd4;
  localparam logic [2:0] REG_CMD_PREFIX   = 3'd5;
  localparam logic [2:0] REG_TERMINATOR   = 3'd6;

  // Reset values of the registers.
  localparam logic [ByteW-1:0] RST_FRAME_START  = 8'd126;
  localparam logic [ByteW-1:0] RST_RX_PKT_TYPE  = 8'd144;
  localparam logic [ByteW-1:0] RST_AT_RESP_TYPE = 8'd136;
  localparam logic [ByteW-1:0] RST_TX_STAT_TYPE = 8'd139;
  localparam logic [ByteW-1:0] RST_HDR_SKIP     = 8'd10;
  localparam logic [ByteW-1:0] RST_CMD_PREFIX   = 8'd0;
  localparam logic [ByteW-1:0] RST_TERMINATOR   = 8'd13;

  // Result kinds.
  localparam logic [KindW-1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [KindW-1:0] KIND_END     = 2'd1;
  localparam logic [KindW-1:0] KIND_RESP    = 2'd2;

  typedef enum logic [3:0] {
    PH_START  = 4'd0,
    PH_LEN_HI = 4'd1,
    PH_LEN_LO = 4'd2,
    PH_TYPE   = 4'd3,
    PH_HEADER = 4'd4,
    PH_PREFIX = 4'd5,
    PH_COUNT  = 4'd6,
    PH_DATA   = 4'd7,
    PH_TERM   = 4'd8,
    PH_RESP   = 4'd9
  } phase_t;

  typedef struct packed {
    logic [ByteW-1:0] frame_start_byte;
    logic [ByteW-1:0] receive_packet_type;
    logic [ByteW-1:0] at_response_type;
    logic [ByteW-1:0] tx_status_type;
    logic [ByteW-1:0] header_skip_count;
    logic [ByteW-1:0] command_prefix_byte;
    logic [ByteW-1:0] terminator_byte;
  } cfg_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [ByteW-1:0] data;
    logic [PosW-1:0]  position;
    logic             last;
    logic             terminator_ok;
  } result_t;

endpackage

// ===== rtl/apifrd_regs.sv =====
module apifrd_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [apifrd_pkg::AddrW-1:0] paddr,
  input  logic [apifrd_pkg::DataW-1:0] pwdata,
  output logic [apifrd_pkg::DataW-1:0] prdata,
  output apifrd_pkg::cfg_t            cfg
);
  import apifrd_pkg::*;

  logic [2:0]       idx;
  logic             wr;
  logic [ByteW-1:0] wbyte;
  logic [ByteW-1:0] rbyte;

  assign idx   = paddr[AddrW-1:2];
  assign wr    = psel && penable && pwrite;
  assign wbyte = pwdata[ByteW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_start_byte    <= RST_FRAME_START;
      cfg.receive_packet_type <= RST_RX_PKT_TYPE;
      cfg.at_response_type    <= RST_AT_RESP_TYPE;
      cfg.tx_status_type      <= RST_TX_STAT_TYPE;
      cfg.header_skip_count   <= RST_HDR_SKIP;
      cfg.command_prefix_byte <= RST_CMD_PREFIX;
      cfg.terminator_byte     <= RST_TERMINATOR;
    end else if (wr) begin
      case (idx)
        REG_FRAME_START:  cfg.frame_start_byte    <= wbyte;
        REG_RX_PKT_TYPE:  cfg.receive_packet_type <= wbyte;
        REG_AT_RESP_TYPE: cfg.at_response_type    <= wbyte;
        REG_TX_STAT_TYPE: cfg.tx_status_type      <= wbyte;
        REG_HDR_SKIP:     cfg.header_skip_count   <= wbyte;
        REG_CMD_PREFIX:   cfg.command_prefix_byte <= wbyte;
        REG_TERMINATOR:   cfg.terminator_byte     <= wbyte;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FRAME_START:  rbyte = cfg.frame_start_byte;
      REG_RX_PKT_TYPE:  rbyte = cfg.receive_packet_type;
      REG_AT_RESP_TYPE: rbyte = cfg.at_response_type;
      REG_TX_STAT_TYPE: rbyte = cfg.tx_status_type;
      REG_HDR_SKIP:     rbyte = cfg.header_skip_count;
      REG_CMD_PREFIX:   rbyte = cfg.command_prefix_byte;
      REG_TERMINATOR:   rbyte = cfg.terminator_byte;
      default:          rbyte = '0;
    endcase
  end

  assign prdata = {{(DataW-ByteW){1'b0}}, rbyte};

endmodule

// ===== rtl/apifrd_core.sv =====
module apifrd_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [apifrd_pkg::ByteW-1:0] byte_in,
  input  apifrd_pkg::cfg_t            cfg,
  output logic                        emit,
  output apifrd_pkg::result_t         res
);
  import apifrd_pkg::*;

  phase_t           phase;
  phase_t           phase_next;
  logic [PosW-1:0]  frame_length;
  logic [PosW-1:0]  frame_length_next;
  logic [ByteW-1:0] header_count;
  logic [ByteW-1:0] header_count_next;
  logic [ByteW-1:0] payload_remaining;
  logic [ByteW-1:0] payload_remaining_next;
  logic [PosW-1:0]  write_position;
  logic [PosW-1:0]  write_position_next;
  logic [PosW-1:0]  response_count;
  logic [PosW-1:0]  response_count_next;

  logic [PosW-1:0]  wp_inc;
  logic [PosW-1:0]  rc_inc;
  logic [ByteW-1:0] pr_dec;
  logic             resp_fin;
  logic             is_resp_type;

  assign wp_inc       = write_position + 16'd1;
  assign rc_inc       = response_count + 16'd1;
  assign pr_dec       = payload_remaining - 8'd1;
  assign resp_fin     = (rc_inc == frame_length);
  assign is_resp_type = (byte_in == cfg.at_response_type) ||
                        (byte_in == cfg.tx_status_type);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_START;
      frame_length      <= '0;
      header_count      <= '0;
      payload_remaining <= '0;
      write_position    <= '0;
      response_count    <= '0;
    end else if (step) begin
      phase             <= phase_next;
      frame_length      <= frame_length_next;
      header_count      <= header_count_next;
      payload_remaining <= payload_remaining_next;
      write_position    <= write_position_next;
      response_count    <= response_count_next;
    end
  end

  // Next state and counters.
  always_comb begin
    phase_next             = phase;
    frame_length_next      = frame_length;
    header_count_next      = header_count;
    payload_remaining_next = payload_remaining;
    write_position_next    = write_position;
    response_count_next    = response_count;
    case (phase)
      PH_LEN_HI: begin
        frame_length_next = {byte_in, 8'h00};
        phase_next        = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        frame_length_next = frame_length | {8'h00, byte_in};
        phase_next        = PH_TYPE;
      end
      PH_TYPE: begin
        if (byte_in == cfg.receive_packet_type) begin
          write_position_next = '0;
          phase_next          = PH_HEADER;
        end else if (is_resp_type) begin
          write_position_next = 16'd1;
          phase_next          = PH_RESP;
        end else begin
          phase_next = PH_START;
        end
      end
      PH_HEADER: begin
        if (header_count == cfg.header_skip_count) begin
          header_count_next = '0;
          phase_next        = PH_PREFIX;
        end else begin
          header_count_next = header_count + 8'd1;
        end
      end
      PH_PREFIX: begin
        if (byte_in == cfg.command_prefix_byte) begin
          write_position_next = '0;
          phase_next          = PH_COUNT;
        end
      end
      PH_COUNT: begin
        payload_remaining_next = byte_in;
        write_position_next    = wp_inc;
        phase_next             = PH_DATA;
      end
      PH_DATA: begin
        write_position_next    = wp_inc;
        payload_remaining_next = pr_dec;
        if (pr_dec == '0) begin
          phase_next = PH_TERM;
        end
      end
      PH_TERM: begin
        phase_next = PH_START;
      end
      PH_RESP: begin
        write_position_next = wp_inc;
        if (resp_fin) begin
          response_count_next = '0;
          phase_next          = PH_START;
        end else begin
          response_count_next = rc_inc;
        end
      end
      default: begin
        phase_next = (byte_in == cfg.frame_start_byte) ? PH_LEN_HI : PH_START;
      end
    endcase
  end

  // Result for the byte at hand.
  always_comb begin
    emit = 1'b0;
    res  = '0;
    case (phase)
      PH_TYPE: begin
        if ((byte_in != cfg.receive_packet_type) && is_resp_type) begin
          emit     = 1'b1;
          res.kind = KIND_RESP;
          res.data = byte_in;
        end
      end
      PH_COUNT, PH_DATA: begin
        emit         = 1'b1;
        res.kind     = KIND_PAYLOAD;
        res.data     = byte_in;
        res.position = write_position;
      end
      PH_TERM: begin
        emit              = 1'b1;
        res.kind          = KIND_END;
        res.last          = 1'b1;
        res.terminator_ok = (byte_in == cfg.terminator_byte);
      end
      PH_RESP: begin
        emit         = 1'b1;
        res.kind     = KIND_RESP;
        res.data     = byte_in;
        res.position = write_position;
        res.last     = resp_fin;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/apifrd_out.sv =====
module apifrd_out (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  apifrd_pkg::result_t res_in,
  input  logic                out_ready,
  output logic                out_valid,
  output logic                room,
  output apifrd_pkg::result_t res_out
);
  import apifrd_pkg::*;

  assign room = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

// ===== rtl/api_frame_receive_decoder.sv =====
// API frame receive decoder.
// Input channel: one received serial byte (rx_byte) per transfer on in_valid/in_ready.
// Output channel: zero or one result per input byte on out_valid/out_ready, carrying
// kind (payload byte, payload end event, response byte), data, position, last and
// terminator_ok. Bytes that only advance the frame parser produce no transfer.
// Configuration: seven 8-bit registers on an APB-style port at byte address 4*index;
// pready is always high, and registers should be written only while the block is idle.
// Data path: an accepted byte is held in an input register and decoded by one pass of the
// frame state machine once the output register has room; its result is loaded into the
// output register, which drives out_valid and the result outputs.
// Throughput: one byte per cycle, sustained, as long as the receiver takes results.
// When the receiver stalls, the finished result waits in the output register and the
// input register still takes one more byte; in_ready falls only once both are full.
// Reset (rst, synchronous) empties both registers, returns the parser to waiting for
// a start byte, clears its counters and restores the register reset values.
module api_frame_receive_decoder (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [apifrd_pkg::AddrW-1:0] paddr,
  input  logic [apifrd_pkg::DataW-1:0] pwdata,
  output logic [apifrd_pkg::DataW-1:0] prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [apifrd_pkg::ByteW-1:0] rx_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [apifrd_pkg::KindW-1:0] kind,
  output logic [apifrd_pkg::ByteW-1:0] data,
  output logic [apifrd_pkg::PosW-1:0]  position,
  output logic                         last,
  output logic                         terminator_ok
);
  import apifrd_pkg::*;

  cfg_t             cfg;
  logic             hold_valid;
  logic [ByteW-1:0] hold_byte;
  logic             room;
  logic             step;
  logic             emit;
  result_t          res;
  result_t          res_q;

  assign pready = 1'b1;

  apifrd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // The held byte is decoded when the output register can take its result,
  // whether or not the byte actually produces one.
  assign step     = hold_valid && room;
  assign in_ready = !hold_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_byte <= rx_byte;
    end
  end

  apifrd_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .byte_in (hold_byte),
    .cfg     (cfg),
    .emit    (emit),
    .res     (res)
  );

  apifrd_out u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step && emit),
    .res_in    (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .room      (room),
    .res_out   (res_q)
  );

  assign kind          = res_q.kind;
  assign data          = res_q.data;
  assign position      = res_q.position;
  assign last          = res_q.last;
  assign terminator_ok = res_q.terminator_ok;

endmodule

// ===== tb/sv/api_frame_receive_decoder_tb.sv =====
`timescale 1ns / 100ps

module api_frame_receive_decoder_tb;
  import apifrd_pkg::*;

  // Clock period is 8 ns, split evenly between the high and low halves.
  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 7;
  // Each side idles in roughly this many cycles out of a hundred.
  localparam int IDLE_PCT     = 21;
  // Cycles allowed after the last expected output before a register write or the end.
  localparam int SETTLE_CYCLES = 4;
  // Watchdog in ns, far above the slowest legal run.
  localparam int WATCHDOG_NS  = 20_000_000;
  localparam int NUM_REGS     = 7;
  // An address past the last register; writes there must be ignored.
  localparam logic [2:0] REG_UNUSED = 3'd7;

  localparam cfg_t RESET_CFG = '{RST_FRAME_START, RST_RX_PKT_TYPE, RST_AT_RESP_TYPE,
                                 RST_TX_STAT_TYPE, RST_HDR_SKIP, RST_CMD_PREFIX,
                                 RST_TERMINATOR};

  logic             clk;
  logic             rst       = 1'b1;
  logic             psel      = 1'b0;
  logic             penable   = 1'b0;
  logic             pwrite    = 1'b0;
  logic [AddrW-1:0] paddr     = '0;
  logic [DataW-1:0] pwdata    = '0;
  logic [DataW-1:0] prdata;
  logic             pready;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  logic [ByteW-1:0] rx_byte   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [KindW-1:0] kind;
  logic [ByteW-1:0] data;
  logic [PosW-1:0]  position;
  logic             last;
  logic             terminator_ok;

  api_frame_receive_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .data          (data),
    .position      (position),
    .last          (last),
    .terminator_ok (terminator_ok)
  );

  always begin
    clk = 1'b0;
    #(HALF_PERIOD);
    clk = 1'b1;
    #(HALF_PERIOD);
  end

  // Shadow copy of the register file and of the frame parser. The parser copy is
  // advanced once for every byte transfer that the decoder accepts.
  cfg_t             shadow_cfg   = RESET_CFG;
  phase_t           track_phase  = PH_START;
  logic [PosW-1:0]  track_len    = '0;
  logic [ByteW-1:0] track_hdr    = '0;
  logic [ByteW-1:0] track_left   = '0;
  logic [PosW-1:0]  track_pos    = '0;
  logic [PosW-1:0]  track_resp   = '0;

  // Decoder outputs that are owed, oldest first.
  result_t outputs_due[$];

  int  mismatch_count = 0;
  int  bytes_sent     = 0;
  // While set, neither side idles: this gives long back-to-back stretches.
  bit  no_idle        = 1'b0;
  // Requested length of a receiver hold-off; the receiver process counts it down.
  int  hold_request   = 0;
  int  hold_left      = 0;

  // Advances the parser copy by one received byte. Returns 1 when the byte
  // produces an output transfer, which is then described in res.
  function automatic bit decode_byte(input logic [ByteW-1:0] b, output result_t res);
    res = '0;
    case (track_phase)
      PH_LEN_HI: begin
        track_len   = {b, 8'h00};
        track_phase = PH_LEN_LO;
        return 1'b0;
      end
      PH_LEN_LO: begin
        track_len   = track_len | {8'h00, b};
        track_phase = PH_TYPE;
        return 1'b0;
      end
      PH_TYPE: begin
        // The receive packet code wins when several type codes are equal.
        if (b == shadow_cfg.receive_packet_type) begin
          track_pos   = '0;
          track_phase = PH_HEADER;
          return 1'b0;
        end
        if (b == shadow_cfg.at_response_type || b == shadow_cfg.tx_status_type) begin
          res.kind    = KIND_RESP;
          res.data    = b;
          track_pos   = 16'd1;
          track_phase = PH_RESP;
          return 1'b1;
        end
        track_phase = PH_START;
        return 1'b0;
      end
      PH_HEADER: begin
        if (track_hdr == shadow_cfg.header_skip_count) begin
          track_hdr   = '0;
          track_phase = PH_PREFIX;
        end else begin
          track_hdr = track_hdr + 8'd1;
        end
        return 1'b0;
      end
      PH_PREFIX: begin
        // The prefix search has no bound; the frame length plays no part here.
        if (b == shadow_cfg.command_prefix_byte) begin
          track_pos   = '0;
          track_phase = PH_COUNT;
        end
        return 1'b0;
      end
      PH_COUNT: begin
        track_left   = b;
        res.kind     = KIND_PAYLOAD;
        res.data     = b;
        res.position = track_pos;
        track_pos    = track_pos + 16'd1;
        track_phase  = PH_DATA;
        return 1'b1;
      end
      PH_DATA: begin
        // A count of zero wraps here, so it stands for 256 payload bytes.
        res.kind     = KIND_PAYLOAD;
        res.data     = b;
        res.position = track_pos;
        track_pos    = track_pos + 16'd1;
        track_left   = track_left - 8'd1;
        if (track_left == 8'd0) track_phase = PH_TERM;
        return 1'b1;
      end
      PH_TERM: begin
        res.kind          = KIND_END;
        res.last          = 1'b1;
        res.terminator_ok = (b == shadow_cfg.terminator_byte);
        track_phase       = PH_START;
        return 1'b1;
      end
      PH_RESP: begin
        // The count is compared after the increment, so a length of zero only
        // completes after 65536 bytes, with the position wrapping on the way.
        res.kind     = KIND_RESP;
        res.data     = b;
        res.position = track_pos;
        track_pos    = track_pos + 16'd1;
        track_resp   = track_resp + 16'd1;
        res.last     = (track_resp == track_len);
        if (res.last) begin
          track_resp  = '0;
          track_phase = PH_START;
        end
        return 1'b1;
      end
      default: begin
        track_phase = (b == shadow_cfg.frame_start_byte) ? PH_LEN_HI : PH_START;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic logic [ByteW-1:0] reg_value(input logic [2:0] idx);
    case (idx)
      REG_FRAME_START:  return shadow_cfg.frame_start_byte;
      REG_RX_PKT_TYPE:  return shadow_cfg.receive_packet_type;
      REG_AT_RESP_TYPE: return shadow_cfg.at_response_type;
      REG_TX_STAT_TYPE: return shadow_cfg.tx_status_type;
      REG_HDR_SKIP:     return shadow_cfg.header_skip_count;
      REG_CMD_PREFIX:   return shadow_cfg.command_prefix_byte;
      REG_TERMINATOR:   return shadow_cfg.terminator_byte;
      default:          return '0;
    endcase
  endfunction

  // Any random byte.
  function automatic logic [ByteW-1:0] rand_byte();
    return ByteW'($urandom_range(255));
  endfunction

  // Any byte except v.
  function automatic logic [ByteW-1:0] other_than(input logic [ByteW-1:0] v);
    logic [ByteW-1:0] flip;
    flip = ByteW'($urandom_range(255, 1));
    return v ^ flip;
  endfunction

  // A type code that none of the three type registers matches.
  function automatic logic [ByteW-1:0] unused_type();
    logic [ByteW-1:0] t;
    t = rand_byte();
    while (t == shadow_cfg.receive_packet_type || t == shadow_cfg.at_response_type ||
           t == shadow_cfg.tx_status_type)
      t = rand_byte();
    return t;
  endfunction

  // Receiver side. It takes output transfers with random gaps, or stalls for a
  // whole hold-off when one is requested, counting the cycles itself.
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left  = hold_left - 1;
    end else if (no_idle) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Every output transfer is matched against the oldest owed output.
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (outputs_due.size() == 0) begin
        $error("unexpected output: kind %0d data %0h position %0d", kind, data, position);
        mismatch_count++;
      end else begin
        want = outputs_due.pop_front();
        if (kind !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, kind);
          mismatch_count++;
        end
        if (data !== want.data) begin
          $error("data: expected %0h, actual %0h", want.data, data);
          mismatch_count++;
        end
        if (position !== want.position) begin
          $error("position: expected %0d, actual %0d", want.position, position);
          mismatch_count++;
        end
        if (last !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, last);
          mismatch_count++;
        end
        if (terminator_ok !== want.terminator_ok) begin
          $error("terminator_ok: expected %0b, actual %0b", want.terminator_ok,
                 terminator_ok);
          mismatch_count++;
        end
      end
    end
  end

  // Offers one byte, after a random gap, and holds it until the transfer
  // happens. The parser copy is advanced at the accepting edge itself.
  task automatic send_byte(input logic [ByteW-1:0] b);
    result_t res;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    if (decode_byte(b, res)) outputs_due.push_back(res);
  endtask

  // Feeds bytes that carry the current frame to its end, so that the parser
  // is back to waiting for a start byte.
  task automatic finish_frame();
    while (track_phase != PH_START) begin
      case (track_phase)
        PH_PREFIX: send_byte(shadow_cfg.command_prefix_byte);
        PH_COUNT:  send_byte(8'd1);
        PH_TYPE:   send_byte(unused_type());
        default:   send_byte(rand_byte());
      endcase
    end
  endtask

  // Lets every owed output arrive, then a few cycles more.
  task automatic drain_decoder();
    in_valid <= 1'b0;
    while (outputs_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [ByteW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {{(DataW-ByteW){1'b0}}, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_FRAME_START:  shadow_cfg.frame_start_byte    = val;
      REG_RX_PKT_TYPE:  shadow_cfg.receive_packet_type = val;
      REG_AT_RESP_TYPE: shadow_cfg.at_response_type    = val;
      REG_TX_STAT_TYPE: shadow_cfg.tx_status_type      = val;
      REG_HDR_SKIP:     shadow_cfg.header_skip_count   = val;
      REG_CMD_PREFIX:   shadow_cfg.command_prefix_byte = val;
      REG_TERMINATOR:   shadow_cfg.terminator_byte     = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Reads a register back and compares it with the shadow copy.
  task automatic apb_read(input logic [2:0] idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== {{(DataW-ByteW){1'b0}}, reg_value(idx)}) begin
      $error("register %0d: expected %0h, actual %0h", idx, reg_value(idx), prdata);
      mismatch_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic read_all_regs();
    logic [2:0] idx;
    for (int i = 0; i < NUM_REGS; i++) begin
      idx = i[2:0];
      apb_read(idx);
    end
  endtask

  // Brings the parser to rest, lets the decoder go idle and loads a full
  // register set. A write past the last register is slipped in as well; the
  // read-back shows that it changed nothing.
  task automatic load_config(input cfg_t c);
    finish_frame();
    drain_decoder();
    apb_write(REG_FRAME_START,  c.frame_start_byte);
    apb_write(REG_RX_PKT_TYPE,  c.receive_packet_type);
    apb_write(REG_AT_RESP_TYPE, c.at_response_type);
    apb_write(REG_TX_STAT_TYPE, c.tx_status_type);
    apb_write(REG_HDR_SKIP,     c.header_skip_count);
    apb_write(REG_CMD_PREFIX,   c.command_prefix_byte);
    apb_write(REG_TERMINATOR,   c.terminator_byte);
    apb_write(REG_UNUSED,       ~c.frame_start_byte);
    read_all_regs();
  endtask

  // A well-formed receive packet: filler bytes before the prefix, a count
  // (zero meaning 256), the payload and a terminator that is right or wrong.
  task automatic send_rx_packet(input int filler, input int count, input bit good_term);
    send_byte(shadow_cfg.frame_start_byte);
    send_byte(rand_byte());
    send_byte(rand_byte());
    send_byte(shadow_cfg.receive_packet_type);
    for (int i = 0; i <= shadow_cfg.header_skip_count; i++) send_byte(rand_byte());
    repeat (filler) send_byte(other_than(shadow_cfg.command_prefix_byte));
    send_byte(shadow_cfg.command_prefix_byte);
    send_byte(count[7:0]);
    repeat ((count == 0) ? 256 : count) send_byte(rand_byte());
    send_byte(good_term ? shadow_cfg.terminator_byte
                        : other_than(shadow_cfg.terminator_byte));
  endtask

  // A well-formed AT response or transmit status frame of the given length.
  task automatic send_response(input logic [PosW-1:0] len, input bit use_at);
    send_byte(shadow_cfg.frame_start_byte);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    send_byte(use_at ? shadow_cfg.at_response_type : shadow_cfg.tx_status_type);
    repeat ((len == 0) ? 65536 : int'(len)) send_byte(rand_byte());
  endtask

  // Random traffic: mostly well-formed frames with random content, and some
  // dropped frames, line noise and frames cut short by a new frame.
  task automatic run_random_frames(input int budget);
    int stop_at;
    int pick;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        send_rx_packet(($urandom_range(3) == 0) ? $urandom_range(6, 1) : 0,
                       ($urandom_range(9) == 0) ? 0 : $urandom_range(12, 1),
                       $urandom_range(4) != 0);
      end else if (pick < 75) begin
        send_response(PosW'(($urandom_range(9) == 0) ? $urandom_range(300, 17)
                                                     : $urandom_range(16, 1)),
                      $urandom_range(1) == 1);
      end else if (pick < 85) begin
        send_byte(shadow_cfg.frame_start_byte);
        send_byte(rand_byte());
        send_byte(rand_byte());
        send_byte(unused_type());
        repeat ($urandom_range(3)) send_byte(rand_byte());
      end else if (pick < 93) begin
        repeat ($urandom_range(4, 1)) send_byte(other_than(shadow_cfg.frame_start_byte));
      end else begin
        // The new start byte lands while the old frame is still in its header or prefix search.
        send_byte(shadow_cfg.frame_start_byte);
        send_byte(rand_byte());
        send_byte(rand_byte());
        send_byte(shadow_cfg.receive_packet_type);
        repeat ($urandom_range(5)) send_byte(rand_byte());
        send_rx_packet(0, $urandom_range(8, 1), 1'b1);
      end
      finish_frame();
    end
  endtask

  task automatic test_reset_values();
    read_all_regs();
  endtask

  // Directed frames under the reset register values.
  task automatic test_directed_frames();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_rx_packet(0, 1, 1'b1);
    send_rx_packet(2, 3, 1'b0);
    // The prefix turns up only after a long run of other bytes.
    send_rx_packet(24, 2, 1'b1);
    // A count byte of zero carries 256 payload bytes.
    send_rx_packet(0, 0, 1'b1);
    send_response(16'd1, 1'b1);
    send_response(16'd3, 1'b0);
    send_byte(shadow_cfg.frame_start_byte);
    send_byte(8'h00);
    send_byte(8'h05);
    send_byte(unused_type());
    finish_frame();
    drain_decoder();
  endtask

  task automatic test_register_extremes();
    cfg_t c;
    // All zero: every type code is equal, so the receive packet path wins.
    c = '0;
    load_config(c);
    send_rx_packet(1, 2, 1'b1);
    send_rx_packet(0, 1, 1'b0);
    send_response(16'd2, 1'b1);
    finish_frame();
    run_random_frames(30);
    // All ones apart from a short header skip: the type codes, the prefix and
    // the terminator all sit at the top of their range.
    c = '1;
    c.header_skip_count = 8'd2;
    load_config(c);
    send_rx_packet(0, 3, 1'b1);
    send_rx_packet(1, 1, 1'b0);
    finish_frame();
    drain_decoder();
  endtask

  // The receiver holds off for a long stretch while a long response keeps
  // coming, so the output and input registers fill and in_ready falls.
  task automatic test_output_backpressure();
    load_config(RESET_CFG);
    hold_request = 64;
    send_response(16'd40, 1'b1);
    finish_frame();
    drain_decoder();
  endtask

  task automatic test_random_settings();
    cfg_t c;
    no_idle = 1'b1;
    load_config(RESET_CFG);
    run_random_frames(70);
    no_idle = 1'b0;
    repeat (3) begin
      c.frame_start_byte    = rand_byte();
      c.receive_packet_type = rand_byte();
      c.at_response_type    = other_than(c.receive_packet_type);
      c.tx_status_type      = other_than(c.receive_packet_type);
      c.header_skip_count   = ByteW'($urandom_range(15));
      c.command_prefix_byte = rand_byte();
      c.terminator_byte     = rand_byte();
      load_config(c);
      run_random_frames(30);
    end
    // Both response codes equal, and no header bytes beyond the first.
    c.tx_status_type    = c.at_response_type;
    c.header_skip_count = '0;
    load_config(c);
    run_random_frames(30);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_directed_frames();
    test_register_extremes();
    test_output_backpressure();
    test_random_settings();
    finish_frame();
    no_idle = 1'b1;
    drain_decoder();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("api_frame_receive_decoder_tb OK");
    end else begin
      $display("api_frame_receive_decoder_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #(WATCHDOG_NS);
    $display("api_frame_receive_decoder_tb NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/apifrd_pkg.sv
rtl/apifrd_regs.sv
rtl/apifrd_core.sv
rtl/apifrd_out.sv
rtl/api_frame_receive_decoder.sv
tb/sv/api_frame_receive_decoder_tb.sv
